### rtl/core/rlps_pkg.sv
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types, codes and helpers of the publish scheduler.
// ----------------------------------------------------------------------------
package rlps_pkg;

    localparam int CMD_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [CMD_W-1:0] CMD_INIT    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_CHANGED = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SNAP    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DUE     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_ATTEMPT = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SUCCESS = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FAIL    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SUSPEND = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REPLAY  = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RA_MAX   = 3'd5;

    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic [19:0] US_PER_MS = 20'd1000;
    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    // ceil(2^20 / 10): exact divide by ten for any 17-bit period
    localparam logic [16:0] HB_RECIP  = 17'd104858;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_LOAD      = 4'd1;
    localparam t_op OP_REF_CHK   = 4'd2;
    localparam t_op OP_REF_APPLY = 4'd3;
    localparam t_op OP_HB_MOD    = 4'd5;
    localparam t_op OP_HB_PREP   = 4'd6;
    localparam t_op OP_BO_INIT   = 4'd7;
    localparam t_op OP_BO_STEP   = 4'd8;
    localparam t_op OP_BO_MOD    = 4'd9;
    localparam t_op OP_BO_PREP   = 4'd10;
    localparam t_op OP_EXEC      = 4'd11;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             susp;
        logic             hb_en;
        logic             need_div;
        logic             bo_cont;
        logic             div_done;
        logic             out_busy;
    } t_dp_stat;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

### rtl/core/rlps_evt_if.sv
// ----------------------------------------------------------------------------
// rlps_evt_if
// Event channel: valid/ready handshake with the event word.
// ----------------------------------------------------------------------------
interface rlps_evt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [63:0] now_us;
    logic        chg_real;
    logic        snap_diff;
    logic        hb_on;
    logic [16:0] hb_period_s;
    logic [31:0] ra_hint_s;
    logic [31:0] rand_word;

    modport source (output valid, command, now_us, chg_real, snap_diff,
                    hb_on, hb_period_s, ra_hint_s,
                    rand_word, input ready);
    modport sink (input valid, command, now_us, chg_real, snap_diff,
                  hb_on, hb_period_s, ra_hint_s,
                  rand_word, output ready);
endinterface

### rtl/core/rlps_res_if.sv
// ----------------------------------------------------------------------------
// rlps_res_if
// Result channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface rlps_res_if;
    logic       valid;
    logic       ready;
    logic       answer;
    logic [7:0] tokens_left;
    logic       is_suspended;
    logic       is_published;

    modport source (output valid, answer, tokens_left, is_suspended, is_published,
                    input ready);
    modport sink (input valid, answer, tokens_left, is_suspended, is_published,
                  output ready);
endinterface

### rtl/core/rlps_div.sv
// ----------------------------------------------------------------------------
// rlps_div
// Restoring 64-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_quot, r_rem, r_div;
    logic [64:0] rem_sh, rem_sub;
    logic        take;

    always_comb begin
        rem_sh  = {r_rem, r_quot[63]};
        rem_sub = rem_sh - {1'b0, r_div};
        take    = rem_sh >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[62:0], take};
            r_rem  <= take ? rem_sub[63:0] : rem_sh[63:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

### rtl/core/rlps_dp.sv
// ----------------------------------------------------------------------------
// rlps_dp
// Datapath: configuration, scheduler state, work registers, divider, result.
// ----------------------------------------------------------------------------
module rlps_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rlps_pkg::t_dp_cmd                    i_cmd,
    output rlps_pkg::t_dp_stat                   o_stat,
    input  logic                                 i_cfg_we,
    input  logic [rlps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rlps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [rlps_pkg::CMD_W-1:0]           i_command,
    input  logic [63:0]                          i_now_us,
    input  logic                                 i_chg_real,
    input  logic                                 i_snap_diff,
    input  logic                                 i_hb_on,
    input  logic [16:0]                          i_hb_period_s,
    input  logic [31:0]                          i_ra_hint_s,
    input  logic [31:0]                          i_rand_word,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_answer,
    output logic [7:0]                           o_tokens_left,
    output logic                                 o_is_suspended,
    output logic                                 o_is_published
);
    import rlps_pkg::*;

    // configuration
    logic [7:0]  r_cap;
    logic [36:0] r_per_us;
    logic [31:0] r_deb_us;
    logic [21:0] r_base_ms, r_max_ms;
    logic [16:0] r_ramax;
    logic [16:0] refill_c;

    // scheduler state
    logic [7:0]  r_tokens, n_tokens;
    logic [63:0] r_rd, n_rd, r_dd, n_dd, r_retry, n_retry, r_hb, n_hb;
    logic        r_dirty, n_dirty, r_pub, n_pub, r_susp, n_susp, r_rr, n_rr;
    logic [31:0] r_fc, n_fc;

    // latched event
    logic [CMD_W-1:0] r_cmd;
    logic [63:0] r_now;
    logic        r_act, r_snap, r_hben;
    logic [16:0] r_hbs;
    logic [31:0] r_hint, r_rnd;

    // work registers
    logic [21:0] r_base, n_base;
    logic [31:0] r_cnt, n_cnt;
    logic [16:0] r_jit, n_jit;
    logic [26:0] r_dly, n_dly;

    // result
    logic        r_ovalid, r_ans, r_osusp, r_opub, n_ans;
    logic [7:0]  r_otok;

    // divider
    logic        div_start, div_done;
    logic [63:0] div_dvd, div_dvs, div_quot, div_rem;

    // helpers
    logic        now_ge_rd, tok_lt_cap, need_div, bo_cont;
    logic [63:0] per_us64, n_val;
    logic [7:0]  room;
    logic        n_lt_room;
    logic [44:0] nper;
    logic [37:0] hb_prod;
    logic [16:0] jit_hb;
    logic [19:0] jit_bo;
    logic [17:0] hb_up;
    logic [22:0] bo_d, bo_dc, base2;
    logic [16:0] hmin;
    logic [26:0] bo_h;
    logic        blocked, hbdue, dd_ok;
    logic [46:0] dly_us;
    logic [63:0] dly_sat;

    assign refill_c = (i_cfg_data[16:0] == 17'd0) ? 17'd1 : i_cfg_data[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= 8'd4;
            r_per_us  <= 37'd60000000;
            r_deb_us  <= 32'd5000000;
            r_base_ms <= 22'd1000;
            r_max_ms  <= 22'd300000;
            r_ramax   <= 17'd3600;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAP:      r_cap     <= i_cfg_data[7:0];
                CFG_REFILL:   r_per_us  <= 37'(refill_c) * 37'(US_PER_S);
                CFG_DEBOUNCE: r_deb_us  <= 32'(i_cfg_data[11:0]) * 32'(US_PER_S);
                CFG_BASE_MS:  r_base_ms <= i_cfg_data[21:0];
                CFG_MAX_MS:   r_max_ms  <= i_cfg_data[21:0];
                CFG_RA_MAX:   r_ramax   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        per_us64   = 64'(r_per_us);
        now_ge_rd  = r_now >= r_rd;
        tok_lt_cap = r_tokens < r_cap;
        need_div   = now_ge_rd && tok_lt_cap;
        bo_cont    = (r_cnt != 32'd0) && (r_base != 22'd0) && (r_base < r_max_ms);
        n_val      = div_quot + 64'd1;
        room       = r_cap - r_tokens;
        n_lt_room  = n_val < 64'(room);
        nper       = 45'(n_val[7:0]) * 45'(r_per_us);
        hb_prod    = 38'(r_hbs) * 38'(HB_RECIP);
        jit_hb     = (hb_prod[36:20] == 17'd0) ? 17'd1 : hb_prod[36:20];
        jit_bo     = r_base[21:2];
        hb_up      = 18'(r_hbs) + div_rem[17:0];
        base2      = {r_base, 1'b0};
        bo_d       = 23'(r_base) - 23'(jit_bo) + div_rem[22:0];
        bo_dc      = (bo_d > 23'(r_max_ms)) ? 23'(r_max_ms) : bo_d;
        hmin       = (r_hint < 32'(r_ramax)) ? r_hint[16:0] : r_ramax;
        bo_h       = 27'(hmin) * 27'(MS_PER_S);
        blocked    = (r_retry != 64'd0) && (r_now < r_retry);
        hbdue      = r_pub && (r_hb != 64'd0) && (r_now >= r_hb);
        dd_ok      = r_dirty && (r_now >= r_dd);
        dly_us     = 47'(r_dly) * ((r_cmd == CMD_FAIL) ? 47'(US_PER_MS) : 47'(US_PER_S));
        dly_sat    = sat_add(r_now, 64'(dly_us));
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd   = 64'(r_rnd);
        div_dvs   = 64'({jit_bo, 1'b1});
        case (i_cmd.op)
            OP_REF_CHK: begin
                div_start = need_div;
                div_dvd   = r_now - r_rd;
                div_dvs   = per_us64;
            end
            OP_HB_MOD: begin
                div_start = 1'b1;
                div_dvs   = 64'({jit_hb, 1'b1});
            end
            OP_BO_MOD: begin
                div_start = 1'b1;
            end
            default: ;
        endcase
    end

    rlps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_tokens = r_tokens;
        n_rd     = r_rd;
        n_dd     = r_dd;
        n_retry  = r_retry;
        n_hb     = r_hb;
        n_dirty  = r_dirty;
        n_pub    = r_pub;
        n_susp   = r_susp;
        n_rr     = r_rr;
        n_fc     = r_fc;
        n_base   = r_base;
        n_cnt    = r_cnt;
        n_jit    = r_jit;
        n_dly    = r_dly;
        n_ans    = 1'b0;
        case (i_cmd.op)
            OP_REF_CHK: begin
                if (now_ge_rd && !tok_lt_cap) begin
                    n_rd = sat_add(r_now, per_us64);
                end
            end
            OP_REF_APPLY: begin
                if (n_lt_room) begin
                    n_tokens = r_tokens + n_val[7:0];
                    n_rd     = sat_add(r_rd, 64'(nper));
                end else begin
                    n_tokens = r_cap;
                    n_rd     = sat_add(r_now, per_us64);
                end
            end
            OP_HB_MOD: n_jit = jit_hb;
            OP_HB_PREP: begin
                n_dly = (hb_up > 18'(r_jit)) ? 27'(hb_up - 18'(r_jit)) : 27'd0;
            end
            OP_BO_INIT: begin
                n_base = r_base_ms;
                n_cnt  = r_fc;
            end
            OP_BO_STEP: begin
                n_base = (base2 < 23'(r_max_ms)) ? base2[21:0] : r_max_ms;
                n_cnt  = r_cnt - 32'd1;
            end
            OP_BO_PREP: begin
                n_dly = (27'(bo_dc) > bo_h) ? 27'(bo_dc) : bo_h;
            end
            OP_EXEC: begin
                case (r_cmd)
                    CMD_INIT: begin
                        n_dirty  = 1'b1;
                        n_dd     = r_now;
                        n_pub    = 1'b0;
                        n_susp   = 1'b0;
                        n_rr     = 1'b0;
                        n_fc     = 32'd0;
                        n_retry  = 64'd0;
                        n_hb     = 64'd0;
                        n_tokens = r_cap;
                        n_rd     = sat_add(r_now, per_us64);
                    end
                    CMD_CHANGED: begin
                        n_dirty = 1'b1;
                        n_dd    = sat_add(r_now, 64'(r_deb_us));
                        if (r_act) begin
                            n_susp = 1'b0;
                        end
                    end
                    CMD_SNAP: begin
                        if (r_susp) begin
                            n_ans = r_dirty;
                        end else if (r_tokens != 8'd0 && !blocked) begin
                            n_ans = dd_ok || hbdue;
                        end
                    end
                    CMD_DUE: begin
                        if (!r_susp && r_tokens != 8'd0 && !blocked) begin
                            if (dd_ok && r_pub && !r_snap) begin
                                n_dirty = 1'b0;
                                n_ans   = hbdue;
                            end else begin
                                n_ans = dd_ok || hbdue;
                            end
                        end
                    end
                    CMD_ATTEMPT: begin
                        if (r_tokens != 8'd0) begin
                            n_tokens = r_tokens - 8'd1;
                            n_dirty  = 1'b0;
                            n_retry  = 64'd0;
                            n_ans    = 1'b1;
                        end
                    end
                    CMD_SUCCESS: begin
                        n_pub   = 1'b1;
                        n_susp  = 1'b0;
                        n_rr    = 1'b0;
                        n_fc    = 32'd0;
                        n_retry = 64'd0;
                        n_hb    = r_hben ? dly_sat : 64'd0;
                    end
                    CMD_FAIL: begin
                        n_fc    = (r_fc == 32'hFFFF_FFFF) ? r_fc : r_fc + 32'd1;
                        n_dirty = 1'b1;
                        n_dd    = r_now;
                        if (r_retry < dly_sat) begin
                            n_retry = dly_sat;
                        end
                    end
                    CMD_SUSPEND: begin
                        n_susp  = 1'b1;
                        n_retry = 64'd0;
                    end
                    CMD_REPLAY: begin
                        if (!r_rr) begin
                            n_rr  = 1'b1;
                            n_ans = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tokens <= 8'd4;
            r_rd     <= 64'd60000000;
            r_dirty  <= 1'b1;
            r_dd     <= '0;
            r_pub    <= 1'b0;
            r_susp   <= 1'b0;
            r_rr     <= 1'b0;
            r_fc     <= '0;
            r_retry  <= '0;
            r_hb     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_tokens <= n_tokens;
            r_rd     <= n_rd;
            r_dirty  <= n_dirty;
            r_dd     <= n_dd;
            r_pub    <= n_pub;
            r_susp   <= n_susp;
            r_rr     <= n_rr;
            r_fc     <= n_fc;
            r_retry  <= n_retry;
            r_hb     <= n_hb;
            if (i_cmd.op == OP_EXEC) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_cnt  <= n_cnt;
        r_jit  <= n_jit;
        r_dly  <= n_dly;
        if (i_cmd.op == OP_LOAD) begin
            r_cmd  <= i_command;
            r_now  <= i_now_us;
            r_act  <= i_chg_real;
            r_snap <= i_snap_diff;
            r_hben <= i_hb_on;
            r_hbs  <= i_hb_period_s;
            r_hint <= i_ra_hint_s;
            r_rnd  <= i_rand_word;
        end
        if (i_cmd.op == OP_EXEC) begin
            r_ans   <= n_ans;
            r_otok  <= n_tokens;
            r_osusp <= n_susp;
            r_opub  <= n_pub;
        end
    end

    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.susp     = r_susp;
        o_stat.hb_en    = r_hben;
        o_stat.need_div = need_div;
        o_stat.bo_cont  = bo_cont;
        o_stat.div_done = div_done;
        o_stat.out_busy = r_ovalid && !i_out_ready;
    end

    assign o_out_valid    = r_ovalid;
    assign o_answer       = r_ans;
    assign o_tokens_left  = r_otok;
    assign o_is_suspended = r_osusp;
    assign o_is_published = r_opub;
endmodule

### rtl/core/rlps_ctrl.sv
// ----------------------------------------------------------------------------
// rlps_ctrl
// Sequencer: steps each event through the refill, jitter or backoff phases its command needs.
// ----------------------------------------------------------------------------
module rlps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_evt_valid,
    output logic               o_evt_ready,
    input  rlps_pkg::t_dp_stat i_stat,
    output rlps_pkg::t_dp_cmd  o_cmd
);
    import rlps_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_REF     = 4'd2;
    localparam logic [3:0] S_REF_W   = 4'd3;
    localparam logic [3:0] S_HB      = 4'd4;
    localparam logic [3:0] S_HBM_W   = 4'd5;
    localparam logic [3:0] S_BO      = 4'd6;
    localparam logic [3:0] S_BO_STEP = 4'd7;
    localparam logic [3:0] S_BOM_W   = 4'd8;
    localparam logic [3:0] S_EXEC    = 4'd9;

    logic [3:0] r_state, n_state;
    t_op        op;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_evt_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.cmd)
                    CMD_SNAP:    n_state = i_stat.susp ? S_EXEC : S_REF;
                    CMD_DUE:     n_state = S_REF;
                    CMD_ATTEMPT: n_state = S_REF;
                    CMD_SUCCESS: n_state = i_stat.hb_en ? S_HB : S_EXEC;
                    CMD_FAIL:    n_state = S_BO;
                    default:     n_state = S_EXEC;
                endcase
            end
            S_REF: begin
                op      = OP_REF_CHK;
                n_state = i_stat.need_div ? S_REF_W : S_EXEC;
            end
            S_REF_W: begin
                if (i_stat.div_done) begin
                    op      = OP_REF_APPLY;
                    n_state = S_EXEC;
                end
            end
            S_HB: begin
                op      = OP_HB_MOD;
                n_state = S_HBM_W;
            end
            S_HBM_W: begin
                if (i_stat.div_done) begin
                    op      = OP_HB_PREP;
                    n_state = S_EXEC;
                end
            end
            S_BO: begin
                op      = OP_BO_INIT;
                n_state = S_BO_STEP;
            end
            S_BO_STEP: begin
                if (i_stat.bo_cont) begin
                    op = OP_BO_STEP;
                end else begin
                    op      = OP_BO_MOD;
                    n_state = S_BOM_W;
                end
            end
            S_BOM_W: begin
                if (i_stat.div_done) begin
                    op      = OP_BO_PREP;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.out_busy) begin
                    op      = OP_EXEC;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_evt_ready = (r_state == S_IDLE);
    assign o_cmd.op    = op;

    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_EXEC) |-> !i_stat.out_busy)
        else $error("result overwritten while pending");

    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt_valid && o_evt_ready) |=> (r_state == S_DISP))
        else $error("accepted word not dispatched");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.div_done)
        else $error("divider finished outside a wait phase");
endmodule

### rtl/core/rate_limited_publish_scheduler_unit.sv
// Path from accept to result valid: flag-only events go straight to the result; a refill check
// without catch-up adds only the check; a catch-up refill or a success with heartbeat adds one
// 64-step division; a failure adds up to 22 backoff doublings plus one division.
// Flow: one word at a time, accepted only in idle; a result waits while the last one is unread.
// Reset: synchronous, active low; loads the default registers and state, no clearing pass.
// ----------------------------------------------------------------------------
// rate_limited_publish_scheduler_unit
// Token bucket publish scheduler with exponential backoff and heartbeat.
// ----------------------------------------------------------------------------
module rate_limited_publish_scheduler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rlps_evt_if.sink                        i_evt,
    rlps_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [rlps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rlps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rlps_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_ready;

    rlps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt.valid),
        .o_evt_ready (w_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rlps_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_command             (i_evt.command),
        .i_now_us              (i_evt.now_us),
        .i_chg_real            (i_evt.chg_real),
        .i_snap_diff           (i_evt.snap_diff),
        .i_hb_on               (i_evt.hb_on),
        .i_hb_period_s         (i_evt.hb_period_s),
        .i_ra_hint_s           (i_evt.ra_hint_s),
        .i_rand_word           (i_evt.rand_word),
        .i_out_ready           (o_res.ready),
        .o_out_valid           (o_res.valid),
        .o_answer              (o_res.answer),
        .o_tokens_left         (o_res.tokens_left),
        .o_is_suspended        (o_res.is_suspended),
        .o_is_published        (o_res.is_published)
    );

    assign i_evt.ready = w_ready;
endmodule
